### hw/rtl/imrt_pkg.sv
// shared types, codes and defaults for the interval map range table
`timescale 1ns / 1ps
package imrt_pkg;

    // default sizes
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;
    localparam int VALUE_BITS_DEF  = 32;

    // command codes
    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHL,
        CELL_INS
    } cell_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_CHK,
        S_DEL,
        S_INSLO,
        S_INSHI,
        S_RES
    } state_t;

endpackage

### hw/rtl/imrt_cell.sv
// one breakpoint cell of the table chain: key, value and compare flags
`timescale 1ns / 1ps
module imrt_cell #(
    parameter int KEY_BITS   = imrt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = imrt_pkg::VALUE_BITS_DEF,
    parameter int CW         = 7,
    parameter int IDX        = 0
) (
    input  logic                  aclk,
    input  imrt_pkg::cell_op_t    op,
    input  logic [CW-1:0]         pos,
    input  logic [KEY_BITS-1:0]   ins_key,
    input  logic [VALUE_BITS-1:0] ins_value,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [VALUE_BITS-1:0] right_value,
    input  logic [CW-1:0]         used_count,
    input  logic [KEY_BITS-1:0]   lo,
    input  logic [KEY_BITS-1:0]   hi,
    input  logic [KEY_BITS-1:0]   probe,
    output logic [KEY_BITS-1:0]   key_q,
    output logic [VALUE_BITS-1:0] value_q,
    output logic                  lt_lo,
    output logic                  le_hi,
    output logic                  le_probe
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  lt_lo_reg, le_hi_reg, le_probe_reg;
    logic                  in_use;

    assign in_use = (MY_IDX < used_count);

    // shift from the neighbors or load the inserted entry
    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        case (op)
            imrt_pkg::CELL_HOLD: begin
            end
            imrt_pkg::CELL_SHL: begin
                if (MY_IDX >= pos) begin
                    key_next   = right_key;
                    value_next = right_value;
                end
            end
            imrt_pkg::CELL_INS: begin
                if (MY_IDX > pos) begin
                    key_next   = left_key;
                    value_next = left_value;
                end else if (MY_IDX == pos) begin
                    key_next   = ins_key;
                    value_next = ins_value;
                end
            end
            default: begin
            end
        endcase
    end

    // entry storage and registered compare flags
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        value_reg    <= value_next;
        lt_lo_reg    <= in_use && (key_reg < lo);
        le_hi_reg    <= in_use && (key_reg <= hi);
        le_probe_reg <= in_use && (key_reg <= probe);
    end

    assign key_q    = key_reg;
    assign value_q  = value_reg;
    assign lt_lo    = lt_lo_reg;
    assign le_hi    = le_hi_reg;
    assign le_probe = le_probe_reg;

endmodule

### hw/rtl/interval_map_range_table_top.sv
// interval map range table: sequencer, selection and the chain of cells
//
// Keeps a sorted table of breakpoints that maps every key to a value.
// Input channel s_*: one word per command. cmd 0 assigns new_value over
// [range_start, range_stop); cmd 1 looks up probe_key. Output channel m_*:
// one word per command with found_value and status (0 done, 1 empty
// interval ignored, 2 table full and assign dropped).
// cfg_we / cfg_wdata write the default value of uncovered keys.
// A lookup, an empty assign or a dropped assign passes through S_CMP,
// S_SEL, S_CHK and S_RES after acceptance. An assign that edits the table
// also runs S_DEL, which shifts once per breakpoint it removes, since the
// cell chain moves entries one place per cycle; S_INSLO and S_INSHI always run.
// One command is in flight at a time; the next is taken while the result
// sits in the output register.
// Reset (aresetn low, synchronous) empties the table, clears the default
// to zero and drops any pending result. A stalled receiver (m_ready low)
// holds the result; the block then takes one more command and waits with
// its result until the output register frees up.
`timescale 1ns / 1ps
module interval_map_range_table_top #(
    parameter int TABLE_DEPTH = imrt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = imrt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = imrt_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [VALUE_BITS-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [KEY_BITS-1:0]   s_range_start,
    input  logic [KEY_BITS-1:0]   s_range_stop,
    input  logic [VALUE_BITS-1:0] s_new_value,
    input  logic [KEY_BITS-1:0]   s_probe_key,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_found_value,
    output logic [1:0]            m_status
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(TABLE_DEPTH);

    imrt_pkg::state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] default_reg;
    logic [CW-1:0]         used_reg, used_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] m_value_reg, m_value_next;
    logic [1:0]            m_status_reg, m_status_next;

    // captured command word
    logic                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   lo_reg, lo_next, hi_reg, hi_next, probe_reg, probe_next;
    logic [VALUE_BITS-1:0] nv_reg, nv_next;

    // selection results and edit bookkeeping
    logic [VALUE_BITS-1:0] before_reg, before_next, at_end_reg, at_end_next;
    logic [VALUE_BITS-1:0] look_reg, look_next;
    logic [CW-1:0]         cnt_lo_reg, cnt_lo_next, cnt_le_reg, cnt_le_next;
    logic [CW-1:0]         del_reg, del_next;
    logic                  ins_lo_reg, ins_lo_next, ins_hi_reg, ins_hi_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic [1:0]            res_status_reg, res_status_next;

    // chain signals
    imrt_pkg::cell_op_t    cell_op;
    logic [CW-1:0]         cell_pos;
    logic [KEY_BITS-1:0]   ins_key;
    logic [VALUE_BITS-1:0] ins_value;
    logic [KEY_BITS-1:0]   key_q   [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] value_q [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] f_lo, f_hi, f_pr;

    // selection of the last matching breakpoint
    logic [VALUE_BITS-1:0] sel_lo_v, sel_hi_v, sel_pr_v;
    logic [CW-1:0]         sel_lo_c, sel_hi_c;
    logic [CW:0]           new_count;
    logic                  want_lo, want_hi;

    // cell chain
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        localparam int LI = (i == 0) ? 0 : i - 1;
        localparam int RI = (i == TABLE_DEPTH - 1) ? i : i + 1;
        imrt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CW         (CW),
            .IDX        (i)
        ) u_cell (
            .aclk        (aclk),
            .op          (cell_op),
            .pos         (cell_pos),
            .ins_key     (ins_key),
            .ins_value   (ins_value),
            .left_key    (key_q[LI]),
            .left_value  (value_q[LI]),
            .right_key   (key_q[RI]),
            .right_value (value_q[RI]),
            .used_count  (used_reg),
            .lo          (lo_reg),
            .hi          (hi_reg),
            .probe       (probe_reg),
            .key_q       (key_q[i]),
            .value_q     (value_q[i]),
            .lt_lo       (f_lo[i]),
            .le_hi       (f_hi[i]),
            .le_probe    (f_pr[i])
        );
    end

    // flags form a prefix; pick the cell at its edge
    always_comb begin
        logic nx_lo, nx_hi, nx_pr;
        sel_lo_v = '0;
        sel_hi_v = '0;
        sel_pr_v = '0;
        sel_lo_c = '0;
        sel_hi_c = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            nx_lo = (i == TABLE_DEPTH - 1) ? 1'b0 : f_lo[(i + 1) % TABLE_DEPTH];
            nx_hi = (i == TABLE_DEPTH - 1) ? 1'b0 : f_hi[(i + 1) % TABLE_DEPTH];
            nx_pr = (i == TABLE_DEPTH - 1) ? 1'b0 : f_pr[(i + 1) % TABLE_DEPTH];
            if (f_lo[i] && !nx_lo) begin
                sel_lo_v = sel_lo_v | value_q[i];
                sel_lo_c = sel_lo_c | CW'(i + 1);
            end
            if (f_hi[i] && !nx_hi) begin
                sel_hi_v = sel_hi_v | value_q[i];
                sel_hi_c = sel_hi_c | CW'(i + 1);
            end
            if (f_pr[i] && !nx_pr) begin
                sel_pr_v = sel_pr_v | value_q[i];
            end
        end
        if (!f_lo[0]) sel_lo_v = default_reg;
        if (!f_hi[0]) sel_hi_v = default_reg;
        if (!f_pr[0]) sel_pr_v = default_reg;
    end

    // size of the table after the assign
    assign want_lo   = (before_reg != nv_reg);
    assign want_hi   = (at_end_reg != nv_reg);
    assign new_count = {1'b0, cnt_lo_reg} + (CW + 1)'(want_lo) + (CW + 1)'(want_hi)
                     + {1'b0, used_reg} - {1'b0, cnt_le_reg};

    // sequencer next state and outputs
    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        cmd_next        = cmd_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        probe_next      = probe_reg;
        nv_next         = nv_reg;
        before_next     = before_reg;
        at_end_next     = at_end_reg;
        look_next       = look_reg;
        cnt_lo_next     = cnt_lo_reg;
        cnt_le_next     = cnt_le_reg;
        del_next        = del_reg;
        ins_lo_next     = ins_lo_reg;
        ins_hi_next     = ins_hi_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        cell_op         = imrt_pkg::CELL_HOLD;
        cell_pos        = cnt_lo_reg;
        ins_key         = lo_reg;
        ins_value       = nv_reg;
        s_ready         = 1'b0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            imrt_pkg::S_IDLE: begin
                s_ready = aresetn;
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    lo_next    = s_range_start;
                    hi_next    = s_range_stop;
                    nv_next    = s_new_value;
                    probe_next = s_probe_key;
                    state_next = imrt_pkg::S_CMP;
                end
            end
            imrt_pkg::S_CMP: begin
                state_next = imrt_pkg::S_SEL;
            end
            imrt_pkg::S_SEL: begin
                before_next = sel_lo_v;
                at_end_next = sel_hi_v;
                look_next   = sel_pr_v;
                cnt_lo_next = sel_lo_c;
                cnt_le_next = sel_hi_c;
                state_next  = imrt_pkg::S_CHK;
            end
            imrt_pkg::S_CHK: begin
                res_value_next = '0;
                if (cmd_reg == imrt_pkg::CMD_LOOKUP) begin
                    res_value_next  = look_reg;
                    res_status_next = imrt_pkg::ST_DONE;
                    state_next      = imrt_pkg::S_RES;
                end else if (!(lo_reg < hi_reg)) begin
                    res_status_next = imrt_pkg::ST_EMPTY;
                    state_next      = imrt_pkg::S_RES;
                end else if (new_count > DEPTH_W) begin
                    res_status_next = imrt_pkg::ST_FULL;
                    state_next      = imrt_pkg::S_RES;
                end else begin
                    del_next    = cnt_le_reg - cnt_lo_reg;
                    ins_lo_next = want_lo;
                    ins_hi_next = want_hi;
                    state_next  = imrt_pkg::S_DEL;
                end
            end
            imrt_pkg::S_DEL: begin
                if (del_reg != '0) begin
                    cell_op   = imrt_pkg::CELL_SHL;
                    used_next = used_reg - 1'b1;
                    del_next  = del_reg - 1'b1;
                end else begin
                    state_next = imrt_pkg::S_INSLO;
                end
            end
            imrt_pkg::S_INSLO: begin
                if (ins_lo_reg) begin
                    cell_op   = imrt_pkg::CELL_INS;
                    used_next = used_reg + 1'b1;
                end
                state_next = imrt_pkg::S_INSHI;
            end
            imrt_pkg::S_INSHI: begin
                cell_pos  = cnt_lo_reg + CW'(ins_lo_reg);
                ins_key   = hi_reg;
                ins_value = at_end_reg;
                if (ins_hi_reg) begin
                    cell_op   = imrt_pkg::CELL_INS;
                    used_next = used_reg + 1'b1;
                end
                res_status_next = imrt_pkg::ST_DONE;
                state_next      = imrt_pkg::S_RES;
            end
            imrt_pkg::S_RES: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = imrt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = imrt_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= imrt_pkg::S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            default_reg <= '0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) default_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
        cmd_reg        <= cmd_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        probe_reg      <= probe_next;
        nv_reg         <= nv_next;
        before_reg     <= before_next;
        at_end_reg     <= at_end_next;
        look_reg       <= look_next;
        cnt_lo_reg     <= cnt_lo_next;
        cnt_le_reg     <= cnt_le_next;
        del_reg        <= del_next;
        ins_lo_reg     <= ins_lo_next;
        ins_hi_reg     <= ins_hi_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found_value = m_value_reg;
    assign m_status      = m_status_reg;

`ifndef NO_ASSERTIONS
    // fill count never exceeds the table
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(TABLE_DEPTH))
        else $error("table fill count beyond depth");

    // range counts are ordered for a nonempty assign
    a_cnt_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imrt_pkg::S_CHK && cmd_reg == imrt_pkg::CMD_ASSIGN && lo_reg < hi_reg)
        |-> (cnt_lo_reg <= cnt_le_reg && cnt_le_reg <= used_reg))
        else $error("breakpoint range counts out of order");

    // a shift only runs over entries in use
    a_edit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imrt_pkg::S_DEL && del_reg != '0)
        |-> (used_reg > cnt_lo_reg))
        else $error("edit sequence broken");

    // the result leaves the sequencer only into a free output register
    a_res_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imrt_pkg::S_RES && m_valid_reg && !m_ready)
        |=> (state_reg == imrt_pkg::S_RES))
        else $error("result dropped while output stalled");
`endif

endmodule

### sim/tb.sv
// self-checking testbench for the interval map range table
`timescale 1ns / 1ps
module tb;

    localparam int DEPTH = imrt_pkg::TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] val;
        logic [31:0] key;
    } word_t;

    typedef struct packed {
        logic [31:0] found;
        logic [1:0]  status;
    } answer_t;

    // directed row: word, whether an answer is typed in, and that answer
    typedef struct packed {
        word_t   w;
        logic    fixed;
        answer_t ans;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = 1'b0;
    logic [31:0] s_range_start = '0;
    logic [31:0] s_range_stop = '0;
    logic [31:0] s_new_value = '0;
    logic [31:0] s_probe_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_found_value;
    logic [1:0]  m_status;

    // shadow copy of the breakpoint table
    logic [31:0] bp_key [DEPTH];
    logic [31:0] bp_val [DEPTH];
    int          bp_used;
    logic [31:0] dflt;

    answer_t     pending_answers[$];
    int          errors;
    int          cycles;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    interval_map_range_table_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_range_start(s_range_start), .s_range_stop(s_range_stop),
        .s_new_value(s_new_value), .s_probe_key(s_probe_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_found_value(m_found_value),
        .m_status(m_status)
    );

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [31:0] value_of(input logic [31:0] k);
        logic [31:0] v;
        v = dflt;
        for (int i = 0; i < bp_used; i++)
            if (bp_key[i] <= k) v = bp_val[i];
        return v;
    endfunction

    // overwrite [lo, hi) and rebuild the canonical table; skip an empty range, drop it if too big
    function automatic logic [1:0] paint_range(input logic [31:0] lo,
                                               input logic [31:0] hi,
                                               input logic [31:0] v);
        logic [31:0] prev_v, end_v;
        logic [31:0] nk [DEPTH+2];
        logic [31:0] nv [DEPTH+2];
        int n;
        if (lo >= hi) return imrt_pkg::ST_EMPTY;
        prev_v = dflt;
        end_v = dflt;
        n = 0;
        for (int i = 0; i < bp_used; i++) begin
            if (bp_key[i] < lo) prev_v = bp_val[i];
            if (bp_key[i] <= hi) end_v = bp_val[i];
        end
        for (int i = 0; i < bp_used && bp_key[i] < lo; i++) begin
            nk[n] = bp_key[i]; nv[n] = bp_val[i]; n++;
        end
        if (prev_v != v) begin
            nk[n] = lo; nv[n] = v; n++;
        end
        if (end_v != v) begin
            nk[n] = hi; nv[n] = end_v; n++;
        end
        for (int i = 0; i < bp_used; i++)
            if (bp_key[i] > hi) begin
                if (n >= DEPTH + 2) return imrt_pkg::ST_FULL;
                nk[n] = bp_key[i]; nv[n] = bp_val[i]; n++;
            end
        if (n > DEPTH) return imrt_pkg::ST_FULL;
        for (int i = 0; i < n; i++) begin
            bp_key[i] = nk[i]; bp_val[i] = nv[i];
        end
        bp_used = n;
        return imrt_pkg::ST_DONE;
    endfunction

    function automatic answer_t predict_answer(input word_t w);
        answer_t a;
        if (w.cmd == imrt_pkg::CMD_LOOKUP) begin
            a.found = value_of(w.key);
            a.status = imrt_pkg::ST_DONE;
        end else begin
            a.found = '0;
            a.status = paint_range(w.lo, w.hi, w.val);
        end
        return a;
    endfunction

    // random gap: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays up across a zero gap, drops only for a real gap
    task automatic send_word(input word_t w, input bit fixed, input answer_t ans);
        answer_t p;
        int g;
        g = gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_cmd <= w.cmd;
        s_range_start <= w.lo;
        s_range_stop <= w.hi;
        s_new_value <= w.val;
        s_probe_key <= w.key;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = predict_answer(w);
        if (fixed && p != ans) begin
            $display("directed row disagrees with the predictor at %0t", $realtime);
            errors++;
        end
        pending_answers.push_back(fixed ? ans : p);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_default(input logic [31:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        dflt = v;
    endtask

    function automatic word_t mk(input logic c, input logic [31:0] lo,
                                 input logic [31:0] hi, input logic [31:0] v,
                                 input logic [31:0] k);
        word_t w;
        w.cmd = c; w.lo = lo; w.hi = hi; w.val = v; w.key = k;
        return w;
    endfunction

    // well-formed random word over a chosen key window
    function automatic word_t rand_word(input logic [31:0] span);
        word_t w;
        logic [31:0] a, b;
        w.cmd = 1'($urandom_range(0, 1));
        a = (span == '1) ? $urandom() : $urandom_range(0, span);
        b = (span == '1) ? $urandom() : $urandom_range(0, span);
        if ($urandom_range(0, 9) != 0 && a > b) begin
            w.lo = b; w.hi = a;
        end else begin
            w.lo = a; w.hi = b;
        end
        w.val = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 5);
        w.key = (span == '1) ? $urandom() : $urandom_range(0, span);
        return w;
    endfunction

    // check answers in order
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $display("unexpected result word at %0t", $realtime);
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if (m_found_value !== e.found) report("found_value", m_found_value, e.found);
                if (m_status !== e.status) report("status", {30'd0, m_status}, {30'd0, e.status});
            end
        end
    end

    // receiver stalls
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            g = gap_len();
            if (g != 0) begin
                m_ready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        answer_t z;
        answer_t emp;
        answer_t full;
        errors = 0;
        cycles = 0;
        bp_used = 0;
        dflt = '0;
        z = '{found: 32'd0, status: imrt_pkg::ST_DONE};
        emp = '{found: 32'd0, status: imrt_pkg::ST_EMPTY};
        full = '{found: 32'd0, status: imrt_pkg::ST_FULL};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        rows.push_back('{mk(imrt_pkg::CMD_LOOKUP, 0, 0, 0, 32'd0), 1'b1, z});
        rows.push_back('{mk(imrt_pkg::CMD_LOOKUP, 0, 0, 0, '1), 1'b1, z});
        rows.push_back('{mk(imrt_pkg::CMD_ASSIGN, 5, 5, 7, 0), 1'b1, emp});
        rows.push_back('{mk(imrt_pkg::CMD_ASSIGN, '1, 0, 7, 0), 1'b1, emp});
        rows.push_back('{mk(imrt_pkg::CMD_ASSIGN, 0, '1, '1, 0), 1'b1, z});
        rows.push_back('{mk(imrt_pkg::CMD_LOOKUP, 0, 0, 0, 32'd0), 1'b1,
                         '{'1, imrt_pkg::ST_DONE}});
        rows.push_back('{mk(imrt_pkg::CMD_LOOKUP, 0, 0, 0, '1), 1'b1, z});
        rows.push_back('{mk(imrt_pkg::CMD_ASSIGN, 10, 20, 3, 0), 1'b0, z});
        rows.push_back('{mk(imrt_pkg::CMD_ASSIGN, 20, 30, 3, 0), 1'b0, z});
        rows.push_back('{mk(imrt_pkg::CMD_ASSIGN, 15, 25, '1, 0), 1'b0, z});
        rows.push_back('{mk(imrt_pkg::CMD_LOOKUP, 0, 0, 0, 32'd19), 1'b0, z});
        rows.push_back('{mk(imrt_pkg::CMD_ASSIGN, 32'h8000_0000, 32'hffff_fffe,
                            32'h5555_aaaa, 32'h1234_5678), 1'b0, z});
        rows.push_back('{mk(imrt_pkg::CMD_LOOKUP, 32'h5a5a_5a5a, 0, 0, 32'hffff_fffe),
                         1'b0, z});
        rows.push_back('{mk(imrt_pkg::CMD_ASSIGN, 0, '1, 0, 0), 1'b1, z});
        foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].ans);
        drain();

        // default changed with the table empty, then fill up to overflow
        write_default('1);
        for (int i = 0; i < 40; i++)
            send_word(mk(imrt_pkg::CMD_ASSIGN, 4 * i, 4 * i + 2, i + 1, 0), 1'b0, z);
        send_word(mk(imrt_pkg::CMD_ASSIGN, 1000, 1001, 9, 0), 1'b1, full);
        send_word(mk(imrt_pkg::CMD_LOOKUP, 0, 0, 0, 32'd1000), 1'b1,
                  '{'1, imrt_pkg::ST_DONE});
        drain();

        // random phases under several defaults
        write_default(32'd0);
        for (int i = 0; i < 200; i++) send_word(rand_word(32'd63), 1'b0, z);
        drain();
        write_default(32'd3);
        for (int i = 0; i < 150; i++) send_word(rand_word(32'd400), 1'b0, z);
        drain();
        write_default($urandom());
        for (int i = 0; i < 150; i++)
            send_word(rand_word(($urandom_range(0, 1) != 0) ? 32'd31 : '1), 1'b0, z);
        drain();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/imrt_pkg.sv
hw/rtl/imrt_cell.sv
hw/rtl/interval_map_range_table_top.sv
sim/tb.sv
